// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the bit packer.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while reset is released.
`define MBP_ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mbp assertion failed");

// Check a property on every clock edge, reset included.
`define MBP_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mbp assertion failed during reset");

`endif

// ===== sv/mbp_pkg.sv =====
// Shared types and constants of the MSB-first bit packer.
// No dependencies; every module of the block imports it.
package mbp_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int MAX_COUNT   = 64;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 2;

    // Input function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // One input item
    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
    } t_out_item;

    // Classified command passed from front to back; bits are left aligned
    typedef struct packed {
        logic               is_flush;
        logic [VALUE_W-1:0] bits;
        logic [COUNT_W-1:0] remain;
    } t_cmd;

    // Command queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== sv/mbp_front.sv =====
// Front end of the bit packer: accepts input items, drops empty writes,
// saturates the count and left-aligns the value bits. Depends on mbp_pkg.
module mbp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mbp_pkg::t_in_item i_in_data,
    input  mbp_pkg::t_q_status i_q_status,
    output logic             o_push,
    output mbp_pkg::t_cmd    o_push_data
);
    import mbp_pkg::*;

    logic               r_valid;
    logic               n_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [COUNT_W-1:0] count_sat;
    logic               is_empty_write;

    // Hold the staged command while the queue is full
    assign o_in_stall  = r_valid && i_q_status.full;
    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_cmd;

    // Classify and align the incoming item
    always_comb begin
        count_sat = (i_in_data.count > COUNT_W'(MAX_COUNT)) ?
                    COUNT_W'(MAX_COUNT) : i_in_data.count;
        is_empty_write = (i_in_data.func == FUNC_APPEND) && (count_sat == '0);
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (!o_in_stall) begin
            n_valid        = i_in_valid && !is_empty_write;
            n_cmd.is_flush = (i_in_data.func == FUNC_FLUSH);
            n_cmd.bits     = i_in_data.value << (COUNT_W'(MAX_COUNT) - count_sat);
            n_cmd.remain   = count_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ===== sv/mbp_queue.sv =====
// Short command queue between the front and back of the bit packer.
// Depends on mbp_pkg for the command and status types.
module mbp_queue #(
    parameter int DEPTH = mbp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mbp_pkg::t_cmd      i_push_data,
    input  logic               i_pop,
    output mbp_pkg::t_cmd      o_head,
    output mbp_pkg::t_q_status o_status
);
    import mbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_level;
    logic [CNT_W-1:0] n_level;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_level == CNT_W'(DEPTH));
    assign o_status.empty = (r_level == '0);
    assign o_head         = r_entry[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_level = r_level + 1'b1;
        end else if (do_pop && !do_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== sv/mbp_back.sv =====
// Back end of the bit packer: merges up to one byte of command bits per cycle into the
// partial byte unless the output stalls; drives the output register. Depends on mbp_pkg.
module mbp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbp_pkg::t_q_status i_q_status,
    input  mbp_pkg::t_cmd      i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mbp_pkg::t_out_item o_out_data
);
    import mbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

    localparam int FILL_W = $clog2(BYTE_BITS);

    t_back_state          r_state;
    t_back_state          n_state;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    logic [BYTE_BITS-1:0] r_partial;
    logic [BYTE_BITS-1:0] n_partial;
    logic [FILL_W-1:0]    r_filled;
    logic [FILL_W-1:0]    n_filled;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_item            r_out_data;
    t_out_item            n_out_data;

    logic                 can_go;
    logic [FILL_W:0]      space;
    logic [FILL_W:0]      take;
    logic [FILL_W:0]      fill_sum;
    logic [BYTE_BITS-1:0] merged;
    logic [COUNT_W-1:0]   remain_next;

    assign can_go      = !r_out_valid || !i_out_stall;
    assign o_q_pop     = (r_state == ST_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Bits that fit this cycle: the free room of the partial byte, or what is left
    always_comb begin
        space       = (FILL_W + 1)'(BYTE_BITS) - {1'b0, r_filled};
        take        = (r_cmd.remain < COUNT_W'(space)) ? r_cmd.remain[FILL_W:0] : space;
        fill_sum    = {1'b0, r_filled} + take;
        merged      = r_partial | (r_cmd.bits[VALUE_W-1 -: BYTE_BITS] >> r_filled);
        remain_next = r_cmd.remain - COUNT_W'(take);
    end

    // Sequence one command: load, then merge and emit until done
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_partial   = r_partial;
        n_filled    = r_filled;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (can_go) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_cmd   = i_q_head;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (can_go) begin
                    if (r_cmd.is_flush) begin
                        // Pad and emit the pending bits as a last byte, if any
                        if (r_filled != '0) begin
                            n_out_valid         = 1'b1;
                            n_out_data.out_byte = r_partial;
                            n_out_data.last     = 1'b1;
                            n_partial           = '0;
                            n_filled            = '0;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_cmd.bits   = r_cmd.bits << take;
                        n_cmd.remain = remain_next;
                        if (fill_sum == (FILL_W + 1)'(BYTE_BITS)) begin
                            // Full byte: no further byte follows once fewer than 8 remain
                            n_out_valid         = 1'b1;
                            n_out_data.out_byte = merged;
                            n_out_data.last     = (remain_next < COUNT_W'(BYTE_BITS));
                            n_partial           = '0;
                            n_filled            = '0;
                        end else begin
                            n_partial = merged;
                            n_filled  = fill_sum[FILL_W-1:0];
                        end
                        if (remain_next == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_partial   <= '0;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_partial   <= n_partial;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
    end

endmodule

// ===== sv/msb_first_bit_packer_core.sv =====
// MSB-first bit packer, top level: front stage, command queue, back stage.
// An item's bits pass the front register, a queue entry and the back command register.
// Throughput: the back stage merges at most 8 bits a cycle unless the output stalls;
// each command is loaded, then merged or flushed, before the next one is loaded.
// Reset (i_rst_n low, synchronous) empties the queue and clears the partial byte.
module msb_first_bit_packer_core #(
    parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mbp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mbp_pkg::t_out_item o_out_data
);
    import mbp_pkg::*;

    t_q_status q_status;
    t_cmd      push_data;
    t_cmd      q_head;
    logic      push;
    logic      pop;

    // Accept and classify items
    mbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Decouple the two sides
    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    // Pack bits and emit bytes
    mbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_head    (q_head),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/mbp_checker.sv =====
// Port-level checks of the bit packer, bound to the top level.
// Depends on mbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mbp_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mbp_pkg::t_out_item o_out_data
);
    import mbp_pkg::*;

    // Hold a stalled result until its transfer
    `MBP_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)
    `MBP_ASSERT_RUN(a_out_stable, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> $stable(o_out_data))
    // Reset leaves no result pending and the input open
    `MBP_ASSERT_ALL(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)
    `MBP_ASSERT_ALL(a_rst_in, i_clk, !i_rst_n |=> !o_in_stall)

endmodule

bind msb_first_bit_packer_core mbp_checker u_mbp_checker (.*);

// ===== verif/tb_msb_first_bit_packer_core.sv =====
// Self-checking testbench for msb_first_bit_packer_core: directed and random
// append/flush traffic against a cycle-free prediction of the packed byte stream.
// Depends on mbp_pkg and the msb_first_bit_packer_core RTL only.
`timescale 1ns / 100ps

module tb_msb_first_bit_packer_core;
    import mbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // Predicted packer state
    logic [BYTE_BITS-1:0] pend_byte;
    logic [2:0]           pend_fill;

    // Bytes predicted but not yet seen on the output
    t_out_item due_bytes[$];
    t_out_item seen_want;

    int idle_pct;
    int err_count;
    int items_sent;
    int flushes_sent;
    int bytes_checked;
    int cycle_cnt;

    msb_first_bit_packer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Work out the bytes one accepted item produces and queue them
    function automatic void pack_into_bytes(t_in_item item);
        t_out_item made[$];
        t_out_item one;
        int        nbits;
        int        k;
        if (item.func == FUNC_FLUSH) begin
            if (pend_fill != 3'd0) begin
                one.out_byte = pend_byte;
                one.last     = 1'b0;
                made.push_back(one);
                pend_byte = '0;
                pend_fill = 3'd0;
            end
        end else begin
            nbits = (item.count > MAX_COUNT) ? MAX_COUNT : int'(item.count);
            // Take the highest of the used bits first
            for (k = nbits; k > 0; k--) begin
                pend_byte[BYTE_BITS-1-pend_fill] = item.value[k-1];
                if (pend_fill == 3'(BYTE_BITS-1)) begin
                    one.out_byte = pend_byte;
                    one.last     = 1'b0;
                    made.push_back(one);
                    pend_byte = '0;
                    pend_fill = 3'd0;
                end else begin
                    pend_fill = pend_fill + 3'd1;
                end
            end
        end
        if (made.size() > 0) made[made.size()-1].last = 1'b1;
        foreach (made[i]) due_bytes.push_back(made[i]);
    endfunction

    // Offer one item, with random idle cycles ahead of it, until it transfers
    task automatic drive_item(logic func, logic [VALUE_W-1:0] value,
                              logic [COUNT_W-1:0] count);
        t_in_item item;
        item.func  = func;
        item.value = value;
        item.count = count;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pack_into_bytes(item);
        items_sent++;
        if (func == FUNC_FLUSH) flushes_sent++;
    endtask

    // Random value with every bit free
    function automatic logic [VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Zero-length writes and flushes with nothing pending
    task automatic test_empty_cases();
        drive_item(FUNC_FLUSH, '0, '0);
        drive_item(FUNC_APPEND, '1, 7'd0);
        drive_item(FUNC_FLUSH, '1, '1);
        drive_item(FUNC_APPEND, rand_value(), 7'd0);
    endtask

    // Full 64-bit writes, aligned and misaligned
    task automatic test_full_width();
        drive_item(FUNC_APPEND, '1, 7'd64);
        drive_item(FUNC_APPEND, '0, 7'd64);
        drive_item(FUNC_APPEND, 64'h5, 7'd3);
        drive_item(FUNC_APPEND, 64'hA5C3_0FF0_1234_8001, 7'd64);
        drive_item(FUNC_APPEND, '1, 7'd5);
        drive_item(FUNC_APPEND, 64'h8000_0000_0000_0001, 7'd64);
    endtask

    // Counts above the maximum saturate
    task automatic test_count_saturation();
        drive_item(FUNC_APPEND, rand_value(), 7'd65);
        drive_item(FUNC_APPEND, '1, 7'd127);
        drive_item(FUNC_APPEND, rand_value(), 7'd100);
    endtask

    // Partial bytes padded with zeros; bits above count ignored
    task automatic test_flush_padding();
        drive_item(FUNC_APPEND, '1, 7'd1);
        drive_item(FUNC_FLUSH, rand_value(), 7'd64);
        drive_item(FUNC_FLUSH, '0, '0);
        drive_item(FUNC_APPEND, 64'hFFFF_FFFF_FFFF_FF2A, 7'd7);
        drive_item(FUNC_APPEND, '1, 7'd1);
        drive_item(FUNC_APPEND, '0, 7'd7);
        drive_item(FUNC_APPEND, rand_value(), 7'd64);
        drive_item(FUNC_FLUSH, '1, '1);
    endtask

    // Mixed traffic, mostly writes with a spread of counts
    task automatic test_random_traffic(int n_items, int pct);
        int r;
        logic [COUNT_W-1:0] cnt;
        idle_pct = pct;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < 5)       cnt = 7'd0;
            else if (r < 11) cnt = 7'($urandom_range(127, 65));
            else if (r < 24) cnt = 7'd64;
            else if (r < 60) cnt = 7'($urandom_range(12, 1));
            else             cnt = 7'($urandom_range(63, 1));
            if ($urandom_range(99) < 12)
                drive_item(FUNC_FLUSH, rand_value(), 7'($urandom_range(127)));
            else
                drive_item(FUNC_APPEND, rand_value(), cnt);
        end
    endtask

    // Receiver stalls at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Compare each output transfer with the oldest predicted byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_bytes.size() == 0) begin
                $error("unexpected output transfer: out_byte %02h last %0b",
                       o_out_data.out_byte, o_out_data.last);
                err_count++;
            end else begin
                seen_want = due_bytes.pop_front();
                bytes_checked++;
                if (o_out_data.out_byte !== seen_want.out_byte) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           seen_want.out_byte, o_out_data.out_byte);
                    err_count++;
                end
                if (o_out_data.last !== seen_want.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           seen_want.last, o_out_data.last);
                    err_count++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d bytes still due", cycle_cnt,
                 due_bytes.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        idle_pct      = 10;
        err_count     = 0;
        items_sent    = 0;
        flushes_sent  = 0;
        bytes_checked = 0;
        pend_byte     = '0;
        pend_fill     = 3'd0;

        // Hold reset, then release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cases();
        test_full_width();
        test_count_saturation();
        test_flush_padding();
        test_random_traffic(150, 10);
        test_random_traffic(140, 0);
        test_random_traffic(150, 10);

        // Drop valid, drain the predicted bytes, then watch for strays
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items (%0d flushes), checked %0d output bytes",
                 items_sent, flushes_sent, bytes_checked);
        $display("counts 0..127 and random idle/stall on both channels covered");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== msb_first_bit_packer_core.f =====
+incdir+sv
sv/mbp_pkg.sv
sv/mbp_front.sv
sv/mbp_queue.sv
sv/mbp_back.sv
sv/msb_first_bit_packer_core.sv
sv/mbp_checker.sv
verif/tb_msb_first_bit_packer_core.sv
